// File: hw/rtl/ptpd_pkg.sv
// Shared constants, codes and item types of the perspective point transform.
package ptpd_pkg;

	localparam int FRAC_BITS    = 16;
	localparam int NUM_MATRICES = 2;
	localparam int CRD_W        = 32;
	localparam int NUM_W        = CRD_W + FRAC_BITS;
	localparam int DIV_STEPS    = NUM_W;

	localparam logic [CRD_W-1:0] COEF_ONE = CRD_W'(64'd1 << FRAC_BITS);

	localparam logic [1:0] FN_LOAD  = 2'd0;
	localparam logic [1:0] FN_XF_A  = 2'd1;
	localparam logic [1:0] FN_XF_AB = 2'd2;

	typedef logic [2:0][CRD_W-1:0] pt_t;

	typedef struct packed {
		logic             vld;
		logic             res;
		logic [1:0]       func;
		logic [4:0]       idx;
		logic [CRD_W-1:0] val;
		logic             act;
		logic             ld;
		logic             sat;
		logic             wz;
	} tag_t;

endpackage

// File: hw/rtl/point_transform_perspective_divide.sv
// Top level of the homogeneous point transform with perspective divide.
// Takes one item per cycle unless a result waits at a stalled output: a coefficient
// load or a point, which is multiplied by matrix A (and then B in view mode) and
// divided by w in Q16.16. The result is held in an output register; each of the
// two passes ends in a divider that settles one quotient bit per stage. Loads
// travel the pipeline in order and give no result; both matrices reset to identity.
module point_transform_perspective_divide (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// coef_index, coef_value, px, py, pz, zero fill
	input  logic [135:0] s_tdata,
	// func
	input  logic [1:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// out_x, out_y, out_z
	output logic [95:0]  m_tdata,
	// w_zero, saturated
	output logic [1:0]   m_tuser
);

	ptpd_pkg::tag_t tag_a, tag_ab, tag_b, tag_bo;
	ptpd_pkg::pt_t  pt_a, pt_ab, pt_bo;
	logic           en;
	logic           res_multi;
	logic           m_tvalid_q;
	logic [95:0]    m_tdata_q;
	logic [1:0]     m_tuser_q;

	assign en = !(m_tvalid_q && !m_tready && tag_bo.vld && tag_bo.res);
	assign s_tready = en;
	assign res_multi = ptpd_pkg::NUM_MATRICES > 1;

	always_comb begin
		tag_a      = '0;
		tag_a.vld  = s_tvalid;
		tag_a.func = s_tuser;
		tag_a.idx  = s_tdata[4:0];
		tag_a.val  = s_tdata[36:5];
		tag_a.res  = (s_tuser == ptpd_pkg::FN_XF_A)
			|| ((s_tuser == ptpd_pkg::FN_XF_AB) && res_multi);
		tag_a.act  = tag_a.res;
		tag_a.ld   = (s_tuser == ptpd_pkg::FN_LOAD) && !s_tdata[4];
		pt_a[0] = s_tdata[68:37];
		pt_a[1] = s_tdata[100:69];
		pt_a[2] = s_tdata[132:101];
	end

	ptpd_pass u_pass_a (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.tag_in  (tag_a),
		.pt_in   (pt_a),
		.tag_out (tag_ab),
		.pt_out  (pt_ab)
	);

	always_comb begin
		tag_b     = tag_ab;
		tag_b.act = tag_ab.res && (tag_ab.func == ptpd_pkg::FN_XF_AB) && !tag_ab.wz;
		tag_b.ld  = (tag_ab.func == ptpd_pkg::FN_LOAD) && tag_ab.idx[4] && res_multi;
	end

	ptpd_pass u_pass_b (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.tag_in  (tag_b),
		.pt_in   (pt_ab),
		.tag_out (tag_bo),
		.pt_out  (pt_bo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (en && tag_bo.vld && tag_bo.res) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en && tag_bo.vld && tag_bo.res) begin
			if (tag_bo.wz) begin
				m_tdata_q <= '0;
				m_tuser_q <= 2'b01;
			end else begin
				m_tdata_q <= {pt_bo[2], pt_bo[1], pt_bo[0]};
				m_tuser_q <= {tag_bo.sat, 1'b0};
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (m_tvalid_q && !m_tready))
		else $error("input stalled without a waiting result");

	a_wz_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[0]) |-> (m_tdata == '0 && !m_tuser[1]))
		else $error("zero w result carries data or saturation");

	a_result_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(en && tag_bo.vld && tag_bo.res) |=> m_tvalid)
		else $error("finished item did not reach the output register");

	a_load_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(tag_bo.vld && tag_bo.func == ptpd_pkg::FN_LOAD) |-> !tag_bo.res)
		else $error("load item marked as producing a result");

endmodule

// File: hw/rtl/ptpd_pass.sv
// One matrix pass: coefficient registers, products, sums and a bit-per-stage divider.
module ptpd_pass (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  ptpd_pkg::tag_t  tag_in,
	input  ptpd_pkg::pt_t   pt_in,
	output ptpd_pkg::tag_t  tag_out,
	output ptpd_pkg::pt_t   pt_out
);

	localparam int F = ptpd_pkg::FRAC_BITS;
	localparam int N = ptpd_pkg::DIV_STEPS;
	localparam logic signed [63:0] S_MAX = 64'sd2147483647;
	localparam logic signed [63:0] S_MIN = -64'sd2147483648;

	logic [31:0]        coef_q [16];
	logic signed [63:0] prod_s1 [4][3];
	logic [31:0]        trans_s1 [4];
	ptpd_pkg::tag_t     tag_s1;
	ptpd_pkg::pt_t      pt_s1;

	logic signed [63:0] sum_c [4];
	logic [31:0]        clp_c [4];
	logic [3:0]         ov_c;
	ptpd_pkg::tag_t     tag_s2_c;

	logic [31:0]        c_s2 [4];
	ptpd_pkg::tag_t     tag_s2;
	ptpd_pkg::pt_t      pt_s2;

	logic [N-1:0]       dv_nq_s  [0:N][3];
	logic [31:0]        dv_rem_s [0:N][3];
	logic               dv_neg_s [0:N][3];
	logic [31:0]        dv_den_s [0:N];
	ptpd_pkg::tag_t     dv_tag_s [0:N];
	ptpd_pkg::pt_t      dv_pt_s  [0:N];

	logic [31:0]        mag_c [4];
	logic [31:0]        q_c [3];
	logic [2:0]         qov_c;
	ptpd_pkg::tag_t     tag_out_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 16; i++) begin
				coef_q[i] <= (i % 5 == 0) ? ptpd_pkg::COEF_ONE : '0;
			end
		end else if (en && tag_in.vld && tag_in.ld) begin
			coef_q[tag_in.idx[3:0]] <= tag_in.val;
		end
	end

	always_comb begin
		tag_s2_c     = tag_s1;
		tag_s2_c.sat = tag_s1.sat | (tag_s1.act & (|ov_c));
		tag_s2_c.wz  = tag_s1.wz | (tag_s1.act & (clp_c[3] == '0));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
		end else if (en) begin
			tag_s1 <= tag_in;
			tag_s2 <= tag_s2_c;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 4; k++) begin
				for (int r = 0; r < 3; r++) begin
					prod_s1[k][r] <= $signed(pt_in[r]) * $signed(coef_q[4*r+k]);
				end
				trans_s1[k] <= coef_q[12+k];
				c_s2[k] <= clp_c[k];
			end
			pt_s1 <= pt_in;
			pt_s2 <= pt_s1;
		end
	end

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			sum_c[k] = (prod_s1[k][0] >>> F) + (prod_s1[k][1] >>> F)
				+ (prod_s1[k][2] >>> F) + 64'($signed(trans_s1[k]));
			ov_c[k] = (sum_c[k] > S_MAX) || (sum_c[k] < S_MIN);
			if (sum_c[k] > S_MAX) begin
				clp_c[k] = 32'h7FFF_FFFF;
			end else if (sum_c[k] < S_MIN) begin
				clp_c[k] = 32'h8000_0000;
			end else begin
				clp_c[k] = sum_c[k][31:0];
			end
		end
	end

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			mag_c[k] = c_s2[k][31] ? (~c_s2[k] + 32'd1) : c_s2[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_tag_s[0] <= '0;
		end else if (en) begin
			dv_tag_s[0] <= tag_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < 3; l++) begin
				dv_nq_s[0][l]  <= {mag_c[l], {F{1'b0}}};
				dv_rem_s[0][l] <= '0;
				dv_neg_s[0][l] <= c_s2[l][31] ^ c_s2[3][31];
			end
			dv_den_s[0] <= mag_c[3];
			dv_pt_s[0]  <= pt_s2;
		end
	end

	for (genvar j = 1; j <= N; j++) begin : g_div
		logic [32:0] t_c [3];
		logic [2:0]  ge_c;

		always_comb begin
			for (int l = 0; l < 3; l++) begin
				t_c[l]  = {dv_rem_s[j-1][l], dv_nq_s[j-1][l][N-1]};
				ge_c[l] = t_c[l] >= {1'b0, dv_den_s[j-1]};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_tag_s[j] <= '0;
			end else if (en) begin
				dv_tag_s[j] <= dv_tag_s[j-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int l = 0; l < 3; l++) begin
					dv_rem_s[j][l] <= ge_c[l] ? 32'(t_c[l] - {1'b0, dv_den_s[j-1]})
						: t_c[l][31:0];
					dv_nq_s[j][l]  <= {dv_nq_s[j-1][l][N-2:0], ge_c[l]};
					dv_neg_s[j][l] <= dv_neg_s[j-1][l];
				end
				dv_den_s[j] <= dv_den_s[j-1];
				dv_pt_s[j]  <= dv_pt_s[j-1];
			end
		end
	end

	always_comb begin
		for (int l = 0; l < 3; l++) begin
			if (dv_neg_s[N][l]) begin
				qov_c[l] = dv_nq_s[N][l] > N'(64'h8000_0000);
				q_c[l] = qov_c[l] ? 32'h8000_0000 : (~dv_nq_s[N][l][31:0] + 32'd1);
			end else begin
				qov_c[l] = dv_nq_s[N][l] > N'(64'h7FFF_FFFF);
				q_c[l] = qov_c[l] ? 32'h7FFF_FFFF : dv_nq_s[N][l][31:0];
			end
		end
	end

	always_comb begin
		tag_out_c     = dv_tag_s[N];
		tag_out_c.sat = dv_tag_s[N].sat | (dv_tag_s[N].act & (|qov_c));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_out <= '0;
		end else if (en) begin
			tag_out <= tag_out_c;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < 3; l++) begin
				pt_out[l] <= dv_tag_s[N].act ? q_c[l] : dv_pt_s[N][l];
			end
		end
	end

endmodule
